[hw/rtl/pool2d_pkg.sv]
// shared constants, types and helpers of the 2-d pooling block
`default_nettype none

package pool2d_pkg;

  // map and window limits
  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_KERNEL   = 8;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_STRIDE   = 8;

  // field and counter widths
  localparam int DATA_W  = 16;
  localparam int ARG_W   = 6;
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int POS_W   = 6;
  localparam int SLOT_W  = $clog2(MAX_KERNEL);
  localparam int KCNT_W  = $clog2(MAX_KERNEL + 1);
  localparam int PH_W    = $clog2(MAX_STRIDE);
  localparam int AREA_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int SUM_W   = DATA_W + $clog2(MAX_KERNEL * MAX_KERNEL);

  // line store geometry
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_KERNEL;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_MODE     = 3'd0,
    REG_CHANNELS      = 3'd1,
    REG_IN_HEIGHT     = 3'd2,
    REG_IN_WIDTH      = 3'd3,
    REG_KERNEL_HEIGHT = 3'd4,
    REG_KERNEL_WIDTH  = 3'd5,
    REG_STRIDE        = 3'd6
  } cfg_reg_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [AREA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  // zero reads as one, too large reads as the limit
  function automatic logic [CFG_DATA_W-1:0] clamp_cfg(input logic [CFG_DATA_W-1:0] v,
                                                      input logic [CFG_DATA_W-1:0] hi);
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = CFG_DATA_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pool2d_ifs.sv]
// sample and result channel interfaces of the 2-d pooling block
`default_nettype none

interface pool2d_in_if;
  import pool2d_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface pool2d_out_if;
  import pool2d_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pooled_value;
  logic [ARG_W-1:0]         argmax_index;
  logic [CH_W-1:0]          out_channel;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic                     map_end;

  modport source(output valid, output pooled_value, output argmax_index, output out_channel,
                 output out_row, output out_col, output map_end, input ready);
  modport sink(input valid, input pooled_value, input argmax_index, input out_channel,
               input out_row, input out_col, input map_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/pool2d_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module pool2d_div (
  input  logic                 clk,
  input  logic                 rst,
  input  pool2d_pkg::div_req_t req,
  output pool2d_pkg::div_rsp_t rsp
);
  import pool2d_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  quo;
  logic [AREA_W-1:0] rem;
  logic [AREA_W-1:0] dvs;
  logic [AREA_W:0]   trial;
  logic              fits;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // one-cycle pulse as the last quotient bit goes in
      done <= !req.start && busy && (cnt == CNT_W'(SUM_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? AREA_W'(trial - {1'b0, dvs}) : AREA_W'(trial);
        quo <= {quo[SUM_W-2:0], fits};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

[hw/rtl/pooling_2d_max_avg.sv]
// top level of the streaming 2-d max / average pooling block
//
// samples enter on in_ch in channel, row, column raster order, one word per
// handshake; each pooled result leaves on out_ch with its channel, output row,
// output column, argmax position and a flag on the last result of the map.
// registers are written through cfg_we / cfg_index / cfg_data, by the user only
// while idle (the block itself does not enforce this); any write to a defined
// register also restarts the map at channel 0, row 0, col 0. a sample that
// closes no window leaves in_ch.ready high. a sample that closes a window holds
// in_ch.ready low while the window is read back from the line store, one entry
// a cycle through its single read port, then in average mode while the sum
// goes through the bit-serial divider (22 quotient bits), and until the result
// moves to the output register. the output register frees the input side: the
// next sample is taken while a result waits, and a new result waits only if
// out_ch still stalls when it is done. reset clears the registers to their
// defaults, the map position and all handshakes; the line store is not cleared,
// since every entry of a window is written earlier in the same channel.
`default_nettype none

module pooling_2d_max_avg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pool2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pool2d_pkg::CFG_DATA_W-1:0]   cfg_data,
  pool2d_in_if.sink                           in_ch,
  pool2d_out_if.source                        out_ch
);
  import pool2d_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINAL
  } state_t;

  // configuration registers
  logic       pool_mode;
  logic [4:0] channels;
  logic [6:0] in_height;
  logic [6:0] in_width;
  logic [3:0] kernel_height;
  logic [3:0] kernel_width;
  logic [3:0] stride;
  logic       cfg_hit;

  // clamped configuration
  logic [4:0] nc;
  logic [6:0] nh;
  logic [6:0] nw;
  logic [3:0] kh;
  logic [3:0] kw;
  logic [3:0] st;
  logic [AREA_W-1:0] area;

  // map position
  logic [COL_W-1:0]  col_pos;
  logic [ROW_W-1:0]  row_pos;
  logic [CH_W-1:0]   channel_pos;
  logic [SLOT_W-1:0] row_slot;
  logic [PH_W-1:0]   col_ph;
  logic [PH_W-1:0]   row_ph;
  logic [POS_W-1:0]  col_q;
  logic [POS_W-1:0]  row_q;

  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              col_ok;
  logic              row_ok;
  logic              last_col;
  logic              last_row;
  logic              last_ch;
  logic              col_ph_wrap;
  logic              row_ph_wrap;
  logic              slot_wrap;
  logic              win_hit;
  logic              win_last;
  logic [COL_W-1:0]  win_col_calc;
  logic [SLOT_W-1:0] start_slot;
  logic              in_fire;

  // sequencer
  state_t            state;
  logic [COL_W-1:0]  win_col;
  logic [SLOT_W-1:0] scan_slot;
  logic [KCNT_W-1:0] scan_i;
  logic [KCNT_W-1:0] scan_j;
  logic [ARG_W-1:0]  scan_idx;
  logic              issue_done;
  logic              rd_pend;
  logic [ARG_W-1:0]  rd_idx;
  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] best;
  logic [ARG_W-1:0]  best_idx;
  logic [CH_W-1:0]   win_ch;
  logic [POS_W-1:0]  win_row;
  logic [POS_W-1:0]  win_colq;
  logic              win_end;

  // line store
  logic [DATA_W-1:0] store [STORE_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [SUM_W-1:0]  rd_ext;

  // output register
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic [ARG_W-1:0]  out_arg;
  logic [CH_W-1:0]   out_chan;
  logic [POS_W-1:0]  out_rowq;
  logic [POS_W-1:0]  out_colq;
  logic              out_last;

  // divider
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DATA_W-1:0] q_lo;
  logic [DATA_W-1:0] avg_val;

  // clamp registers into range
  assign nc   = 5'(clamp_cfg({2'b0, channels}, CFG_DATA_W'(MAX_CHANNELS)));
  assign nh   = clamp_cfg(in_height, CFG_DATA_W'(MAX_HEIGHT));
  assign nw   = clamp_cfg(in_width, CFG_DATA_W'(MAX_WIDTH));
  assign kh   = 4'(clamp_cfg({3'b0, kernel_height}, CFG_DATA_W'(MAX_KERNEL)));
  assign kw   = 4'(clamp_cfg({3'b0, kernel_width}, CFG_DATA_W'(MAX_KERNEL)));
  assign st   = 4'(clamp_cfg({3'b0, stride}, CFG_DATA_W'(MAX_STRIDE)));
  assign area = AREA_W'({4'b0, kh} * {4'b0, kw});

  // register decode
  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_POOL_MODE, REG_CHANNELS, REG_IN_HEIGHT, REG_IN_WIDTH,
      REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH, REG_STRIDE: cfg_hit = 1'b1;
      default:                                         cfg_hit = 1'b0;
    endcase
  end

  // position tests for the incoming word
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign col_inc      = {1'b0, col_pos} + (COL_W+1)'(1);
  assign row_inc      = {1'b0, row_pos} + (ROW_W+1)'(1);
  assign col_ok       = 7'(col_inc) >= {3'b0, kw};
  assign row_ok       = 7'(row_inc) >= {3'b0, kh};
  assign last_col     = 7'(col_inc) >= nw;
  assign last_row     = 7'(row_inc) >= nh;
  assign last_ch      = ({1'b0, channel_pos} + 5'd1) >= nc;
  assign col_ph_wrap  = ({1'b0, col_ph} + 4'd1) >= st;
  assign row_ph_wrap  = ({1'b0, row_ph} + 4'd1) >= st;
  assign slot_wrap    = ({1'b0, row_slot} + 4'd1) >= kh;
  assign win_hit      = col_ok && row_ok && (col_ph == '0) && (row_ph == '0);
  assign win_last     = last_ch && ((8'(row_inc) + 8'(st)) > {1'b0, nh})
                                && ((8'(col_inc) + 8'(st)) > {1'b0, nw});
  assign win_col_calc = COL_W'(7'(col_inc) - {3'b0, kw});
  assign start_slot   = slot_wrap ? '0 : row_slot + SLOT_W'(1);

  // configuration and map position
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode     <= 1'b0;
      channels      <= 5'd1;
      in_height     <= 7'd8;
      in_width      <= 7'd8;
      kernel_height <= 4'd2;
      kernel_width  <= 4'd2;
      stride        <= 4'd2;
      col_pos       <= '0;
      row_pos       <= '0;
      channel_pos   <= '0;
      row_slot      <= '0;
      col_ph        <= '0;
      row_ph        <= '0;
      col_q         <= '0;
      row_q         <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_POOL_MODE:     pool_mode     <= cfg_data[0];
        REG_CHANNELS:      channels      <= cfg_data[4:0];
        REG_IN_HEIGHT:     in_height     <= cfg_data;
        REG_IN_WIDTH:      in_width      <= cfg_data;
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[3:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[3:0];
        REG_STRIDE:        stride        <= cfg_data[3:0];
        default: begin
        end
      endcase
      if (cfg_hit) begin
        col_pos     <= '0;
        row_pos     <= '0;
        channel_pos <= '0;
        row_slot    <= '0;
        col_ph      <= '0;
        row_ph      <= '0;
        col_q       <= '0;
        row_q       <= '0;
      end
    end else if (in_fire) begin
      if (last_col) begin
        col_pos <= '0;
        col_ph  <= '0;
        col_q   <= '0;
        if (last_row) begin
          row_pos     <= '0;
          row_slot    <= '0;
          row_ph      <= '0;
          row_q       <= '0;
          channel_pos <= last_ch ? '0 : channel_pos + CH_W'(1);
        end else begin
          row_pos  <= row_pos + ROW_W'(1);
          row_slot <= start_slot;
          if (row_ok) begin
            row_ph <= row_ph_wrap ? '0 : row_ph + PH_W'(1);
            row_q  <= row_ph_wrap ? row_q + POS_W'(1) : row_q;
          end
        end
      end else begin
        col_pos <= COL_W'(col_inc);
        if (col_ok) begin
          col_ph <= col_ph_wrap ? '0 : col_ph + PH_W'(1);
          col_q  <= col_ph_wrap ? col_q + POS_W'(1) : col_q;
        end
      end
    end
  end

  // line store: written on every word, read one entry a cycle during a scan
  assign wr_addr = {row_slot, col_pos};
  assign rd_en   = (state == ST_SCAN) && !issue_done;
  assign rd_addr = {scan_slot, win_col + COL_W'(scan_j)};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      store[wr_addr] <= in_ch.sample;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  assign rd_ext = {{(SUM_W-DATA_W){rd_data[DATA_W-1]}}, rd_data};

  // divider hookup and sign fix
  assign div_req.start    = (state == ST_DIV_START);
  assign div_req.dividend = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
  assign div_req.divisor  = area;
  assign q_lo             = div_rsp.quotient[DATA_W-1:0];
  assign avg_val          = sum[SUM_W-1] ? (~q_lo + DATA_W'(1)) : q_lo;

  pool2d_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_done <= 1'b0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // the final step either reloads the output register or leaves it waiting
      if (out_valid && out_ch.ready && (state != ST_FINAL)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && win_hit) begin
            state      <= ST_SCAN;
            scan_slot  <= start_slot;
            scan_i     <= '0;
            scan_j     <= '0;
            scan_idx   <= '0;
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            win_col    <= win_col_calc;
            win_ch     <= channel_pos;
            win_row    <= row_q;
            win_colq   <= col_q;
            win_end    <= win_last;
          end
        end
        ST_SCAN: begin
          // issue the next window entry
          rd_pend <= rd_en;
          rd_idx  <= scan_idx;
          if (rd_en) begin
            scan_idx <= scan_idx + ARG_W'(1);
            if ((scan_j + KCNT_W'(1)) >= kw) begin
              scan_j    <= '0;
              scan_slot <= (({1'b0, scan_slot} + 4'd1) >= kh) ? '0 : scan_slot + SLOT_W'(1);
              if ((scan_i + KCNT_W'(1)) >= kh) begin
                issue_done <= 1'b1;
              end else begin
                scan_i <= scan_i + KCNT_W'(1);
              end
            end else begin
              scan_j <= scan_j + KCNT_W'(1);
            end
          end
          // fold the entry read last cycle
          if (rd_pend) begin
            sum <= (rd_idx == '0) ? rd_ext : sum + rd_ext;
            if ((rd_idx == '0) || ($signed(rd_data) > $signed(best))) begin
              best     <= rd_data;
              best_idx <= rd_idx;
            end
          end
          if (issue_done && !rd_pend) begin
            state <= pool_mode ? ST_DIV_START : ST_FINAL;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            best  <= avg_val;
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_value <= best;
            out_arg   <= pool_mode ? '0 : best_idx;
            out_chan  <= win_ch;
            out_rowq  <= win_row;
            out_colq  <= win_colq;
            out_last  <= win_end;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state == ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.pooled_value = out_value;
  assign out_ch.argmax_index = out_arg;
  assign out_ch.out_channel  = out_chan;
  assign out_ch.out_row      = out_rowq;
  assign out_ch.out_col      = out_colq;
  assign out_ch.map_end      = out_last;

endmodule

`default_nettype wire

[hw/rtl/pool2d_chk.sv]
// port-level checks of the 2-d pooling block and their binding
`default_nettype none

module pool2d_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [pool2d_pkg::DATA_W-1:0]       pooled_value,
  input logic [pool2d_pkg::ARG_W-1:0]        argmax_index,
  input logic [pool2d_pkg::CH_W-1:0]         out_channel,
  input logic [pool2d_pkg::POS_W-1:0]        out_row,
  input logic [pool2d_pkg::POS_W-1:0]        out_col,
  input logic                                map_end
);

  // the block comes out of reset ready for a word
  a_ready_after_rst: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // a new result is only loaded while the sequencer holds the input off
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy sequencer");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pooled_value) && $stable(argmax_index)
      && $stable(out_channel) && $stable(out_row) && $stable(out_col) && $stable(map_end))
    else $error("result payload changed while stalled");

endmodule

bind pooling_2d_max_avg pool2d_chk u_pool2d_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pooled_value (out_ch.pooled_value),
  .argmax_index (out_ch.argmax_index),
  .out_channel  (out_ch.out_channel),
  .out_row      (out_ch.out_row),
  .out_col      (out_ch.out_col),
  .map_end      (out_ch.map_end)
);

`default_nettype wire

[tb/pool2d_window_checker.sv]
// checker of the 2-d pooling block: predicts every pooled word and compares it on arrival
`default_nettype none

module pool2d_window_checker
  import pool2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pool2d_in_if                  in_ch,
  pool2d_out_if                 out_ch,
  output int                    fail_count,
  output int                    pending,
  output int                    words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [ARG_W-1:0]         arg;
    logic [CH_W-1:0]          chan;
    logic [POS_W-1:0]         orow;
    logic [POS_W-1:0]         ocol;
    logic                     last;
  } pooled_t;

  // register copies as last written
  logic       mode_r;
  logic [4:0] chan_r;
  logic [6:0] height_r;
  logic [6:0] width_r;
  logic [3:0] kh_r;
  logic [3:0] kw_r;
  logic [3:0] stride_r;

  // predicted line store and raster position of the next sample
  logic signed [DATA_W-1:0] rows_mem [STORE_DEPTH];
  int unsigned              ch_at;
  int unsigned              row_at;
  int unsigned              col_at;

  pooled_t pooled_q[$];

  // zero counts as one, anything above the limit as the limit
  function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // store one sample, return 1 with the pooled word when it closes an aligned window
  function automatic bit pool_sample(input logic signed [DATA_W-1:0] s, output pooled_t w);
    int unsigned nc, nh, nw, kh, kw, st;
    int unsigned r, c, ch, r0, c0, idx, arg, i, j;
    int          best, sum, v;
    bit          hit;
    nc  = fit(chan_r, MAX_CHANNELS);
    nh  = fit(height_r, MAX_HEIGHT);
    nw  = fit(width_r, MAX_WIDTH);
    kh  = fit(kh_r, MAX_KERNEL);
    kw  = fit(kw_r, MAX_KERNEL);
    st  = fit(stride_r, MAX_STRIDE);
    hit = 1'b0;
    w   = '0;
    if (col_at >= nw || row_at >= nh || ch_at >= nc) begin
      ch_at  = 0;
      row_at = 0;
      col_at = 0;
    end
    r  = row_at;
    c  = col_at;
    ch = ch_at;
    rows_mem[((r % kh) * MAX_WIDTH + c) % STORE_DEPTH] = s;

    if (r + 1 >= kh && c + 1 >= kw) begin
      r0 = r + 1 - kh;
      c0 = c + 1 - kw;
      if (r0 % st == 0 && c0 % st == 0) begin
        best = 0;
        sum  = 0;
        arg  = 0;
        // scan the window row-major, first maximum wins
        for (i = 0; i < kh; i++) begin
          for (j = 0; j < kw; j++) begin
            idx = (((r0 + i) % kh) * MAX_WIDTH + c0 + j) % STORE_DEPTH;
            v   = rows_mem[idx];
            sum += v;
            if ((i == 0 && j == 0) || v > best) begin
              best = v;
              arg  = i * kw + j;
            end
          end
        end
        if (mode_r) begin
          best = sum / int'(kh * kw);
          arg  = 0;
        end
        w.value = best[DATA_W-1:0];
        w.arg   = arg[ARG_W-1:0];
        w.chan  = ch[CH_W-1:0];
        w.orow  = POS_W'(r0 / st);
        w.ocol  = POS_W'(c0 / st);
        w.last  = (ch + 1 == nc && r0 + st + kh > nh && c0 + st + kw > nw);
        hit     = 1'b1;
      end
    end

    // advance the raster position
    c++;
    if (c >= nw) begin
      c = 0;
      r++;
      if (r >= nh) begin
        r = 0;
        ch++;
        if (ch >= nc) ch = 0;
      end
    end
    col_at = c;
    row_at = r;
    ch_at  = ch;
    return hit;
  endfunction

  function automatic int check_field(input string name, input int want, input int seen);
    if (want == seen) return 0;
    $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    return 1;
  endfunction

  // follow register writes, samples and pooled words at every edge
  always @(posedge clk) begin : watch
    pooled_t want;
    int      bad;
    bit      restart;
    bad = 0;
    if (rst) begin
      mode_r   = 1'b0;
      chan_r   = 5'd1;
      height_r = 7'd8;
      width_r  = 7'd8;
      kh_r     = 4'd2;
      kw_r     = 4'd2;
      stride_r = 4'd2;
      ch_at    = 0;
      row_at   = 0;
      col_at   = 0;
      pooled_q.delete();
    end else begin
      if (cfg_we) begin
        restart = 1'b1;
        case (cfg_index)
          REG_POOL_MODE:     mode_r   = cfg_data[0];
          REG_CHANNELS:      chan_r   = cfg_data[4:0];
          REG_IN_HEIGHT:     height_r = cfg_data;
          REG_IN_WIDTH:      width_r  = cfg_data;
          REG_KERNEL_HEIGHT: kh_r     = cfg_data[3:0];
          REG_KERNEL_WIDTH:  kw_r     = cfg_data[3:0];
          REG_STRIDE:        stride_r = cfg_data[3:0];
          default:           restart  = 1'b0;
        endcase
        if (restart) begin
          ch_at  = 0;
          row_at = 0;
          col_at = 0;
        end
      end

      // expected words queue up in arrival order
      if (in_ch.valid && in_ch.ready) begin
        if (pool_sample(in_ch.sample, want)) pooled_q = {pooled_q, want};
      end

      if (out_ch.valid && out_ch.ready) begin
        if (pooled_q.size() == 0) begin
          $display("time %0t: pooled word with nothing expected, value %0d ch %0d row %0d col %0d",
                   $time, out_ch.pooled_value, out_ch.out_channel, out_ch.out_row,
                   out_ch.out_col);
          bad = 1;
        end else begin
          want = pooled_q.pop_front();
          bad  = check_field("pooled_value", want.value, out_ch.pooled_value)
               + check_field("argmax_index", want.arg, out_ch.argmax_index)
               + check_field("out_channel", want.chan, out_ch.out_channel)
               + check_field("out_row", want.orow, out_ch.out_row)
               + check_field("out_col", want.ocol, out_ch.out_col)
               + check_field("map_end", want.last, out_ch.map_end);
        end
        words_checked <= words_checked + 1;
      end
    end
    fail_count <= fail_count + bad;
    pending    <= pooled_q.size();
  end

endmodule

`default_nettype wire

[tb/tb_pooling_2d_max_avg.sv]
// testbench top of the 2-d pooling block: clock, reset, stimulus, pacing and verdict
`default_nettype none

module tb_pooling_2d_max_avg;
  timeunit 1ns;
  timeprecision 1ps;
  import pool2d_pkg::*;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // window read-back plus divider plus output move, with margin
  localparam int LATENCY       = 128;
  localparam int SAMPLE_BUDGET = 1650;

  typedef struct {
    logic                  mode;
    logic [CFG_DATA_W-1:0] chans;
    logic [CFG_DATA_W-1:0] rows;
    logic [CFG_DATA_W-1:0] cols;
    logic [CFG_DATA_W-1:0] k_rows;
    logic [CFG_DATA_W-1:0] k_cols;
    logic [CFG_DATA_W-1:0] step;
  } map_setup_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int words_checked;
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int setups_done = 0;

  pool2d_in_if  in_ch();
  pool2d_out_if out_ch();

  pooling_2d_max_avg u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pool2d_window_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  // receiver stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic map_setup_t make_setup(input logic mode, input int unsigned ch,
                                            input int unsigned h, input int unsigned w,
                                            input int unsigned kh, input int unsigned kw,
                                            input int unsigned st);
    map_setup_t m;
    m.mode   = mode;
    m.chans  = CFG_DATA_W'(ch);
    m.rows   = CFG_DATA_W'(h);
    m.cols   = CFG_DATA_W'(w);
    m.k_rows = CFG_DATA_W'(kh);
    m.k_cols = CFG_DATA_W'(kw);
    m.step   = CFG_DATA_W'(st);
    return m;
  endfunction

  // mostly small maps with fitting windows, now and then out-of-range values
  function automatic map_setup_t random_setup();
    int unsigned ch, h, w, eh, ew, kh, kw, st;
    ch = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(0, 31);
    h  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 9) : $urandom_range(0, 127);
    w  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 9) : $urandom_range(0, 127);
    eh = (h == 0) ? 1 : (h > 8 ? 8 : h);
    ew = (w == 0) ? 1 : (w > 8 ? 8 : w);
    kh = ($urandom_range(0, 3) != 0) ? $urandom_range(1, eh) : $urandom_range(0, 15);
    kw = ($urandom_range(0, 3) != 0) ? $urandom_range(1, ew) : $urandom_range(0, 15);
    st = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 3) : $urandom_range(0, 15);
    return make_setup(1'($urandom_range(0, 1)), ch, h, w, kh, kw, st);
  endfunction

  // extremes, small values for ties, and full-range noise
  function automatic logic [DATA_W-1:0] pick_sample();
    logic [DATA_W-1:0] s;
    case ($urandom_range(0, 7))
      0:       s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2:    s = DATA_W'($urandom_range(0, 6) - 3);
      default: s = DATA_W'($urandom);
    endcase
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic load_setup(input map_setup_t m);
    write_reg(REG_POOL_MODE, CFG_DATA_W'(m.mode));
    write_reg(REG_CHANNELS, m.chans);
    write_reg(REG_IN_HEIGHT, m.rows);
    write_reg(REG_IN_WIDTH, m.cols);
    write_reg(REG_KERNEL_HEIGHT, m.k_rows);
    write_reg(REG_KERNEL_WIDTH, m.k_cols);
    write_reg(REG_STRIDE, m.step);
    cfg_we <= 1'b0;
    @(posedge clk);
    setups_done++;
  endtask

  // one sample word, after a random gap
  task automatic send_sample(input logic [DATA_W-1:0] s);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender until every pooled word is back, then wait out the block
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // stimulus
  initial begin
    map_setup_t setup;
    int         phase, count, pause_at, i, guard, leftover;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // max over 2x2, tie on the positive extreme keeps the first position
    load_setup(make_setup(1'b0, 1, 2, 2, 2, 2, 2));
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    // a write to an unused index must not restart the map
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    settle(LATENCY);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    send_sample(16'h0100);
    send_sample(16'h0002);

    // average at both extremes and truncation of a negative sum
    settle(LATENCY);
    load_setup(make_setup(1'b1, 1, 2, 2, 2, 2, 2));
    repeat (4) send_sample(16'h7FFF);
    repeat (4) send_sample(16'h8000);
    send_sample(16'hFFFB);
    repeat (3) send_sample(16'h0000);

    // window larger than the map gives nothing
    settle(LATENCY);
    load_setup(make_setup(1'b0, 1, 1, 1, 2, 2, 1));
    send_sample(16'h1234);
    send_sample(16'hEDCB);

    // all size and stride registers zero behave as one, in max mode
    settle(LATENCY);
    load_setup(make_setup(1'b0, 0, 0, 0, 0, 0, 0));
    send_sample(16'h1234);
    send_sample(16'h8001);

    // random settings, the first one all at the upper extreme
    phase = 0;
    while (items_sent < SAMPLE_BUDGET) begin
      if (phase == 0) begin
        setup = make_setup(1'($urandom_range(0, 1)), 31, 127, 127, 15, 15, 15);
        count = 512;
      end else begin
        setup = random_setup();
        count = $urandom_range(12, 70);
      end
      settle(LATENCY);
      case (phase % 5)
        1:       begin idle_pct = 75; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 75; end
        3:       begin idle_pct = 20; stall_pct = 20; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      load_setup(setup);
      pause_at = (phase == 1 || $urandom_range(0, 3) == 0) ? $urandom_range(1, count - 1) : -1;
      for (i = 0; i < count; i++) begin
        if (i == pause_at) settle(0);
        send_sample(pick_sample());
      end
      phase++;
    end

    // drain with a bound
    idle_pct  = 0;
    stall_pct = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
    leftover = pending;
    if (leftover != 0) $display("%0d pooled words never arrived", leftover);

    $display("covered %0d samples over %0d register settings, %0d pooled words checked",
             items_sent, setups_done, words_checked);
    $display("max and average modes, 1x1 maps up to 16 channels of 64x64 with 8x8 windows");
    if (fail_count == 0 && leftover == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
